/* design/hybrid_tick_task_scheduler_assert.svh */
// ---------------------------------------------------------------------------
// hybrid tick task scheduler assertion macros
// clocked property checks shared by the scheduler rtl
// ---------------------------------------------------------------------------
`ifndef HYBRID_TICK_TASK_SCHEDULER_ASSERT_SVH
`define HYBRID_TICK_TASK_SCHEDULER_ASSERT_SVH

// check outside reset
`define HTTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check that also holds while reset is applied
`define HTTS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* design/htts_pkg.sv */
// ---------------------------------------------------------------------------
// htts_pkg
// shared types, codes and field layout of the tick task scheduler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int DELAY_BITS_DEF = 16;

    localparam int SLOT_W        = 3;
    localparam int KIND_W        = 2;
    localparam int PEND_W        = 8;
    localparam int FIELD_DELAY_W = 16;
    localparam int MAX_RESULTS   = 8;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    // input beat layout
    localparam int IN_PRES_LSB   = SLOT_W;
    localparam int IN_DELAY_LSB  = IN_PRES_LSB + 1;
    localparam int IN_PERIOD_LSB = IN_DELAY_LSB + FIELD_DELAY_W;
    localparam int IN_COOP_LSB   = IN_PERIOD_LSB + FIELD_DELAY_W;
    localparam int IN_DATA_W     = ((IN_COOP_LSB + 1 + 7) / 8) * 8;

    // output beat layout
    localparam int OUT_USED_W = SLOT_W + PEND_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd3;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic              due;
        logic [KIND_W-1:0] kind;
    } head_stat_t;

endpackage

`default_nettype wire

/* design/htts_cell.sv */
// ---------------------------------------------------------------------------
// htts_cell
// one task slot of the rotating slot chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htts_cell #(
    parameter int DELAY_BITS = htts_pkg::DELAY_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire htts_pkg::cell_ctrl_t         ctrl,
    input  wire logic                         nb_valid,
    input  wire logic [DELAY_BITS-1:0]        nb_delay,
    input  wire logic [DELAY_BITS-1:0]        nb_period,
    input  wire logic                         nb_coop,
    input  wire logic [htts_pkg::PEND_W-1:0]  nb_pend,
    input  wire logic                         ld_valid,
    input  wire logic [DELAY_BITS-1:0]        ld_delay,
    input  wire logic [DELAY_BITS-1:0]        ld_period,
    input  wire logic                         ld_coop,
    output logic                              valid,
    output logic [DELAY_BITS-1:0]             delay,
    output logic [DELAY_BITS-1:0]             period,
    output logic                              coop,
    output logic [htts_pkg::PEND_W-1:0]       pend
);

    import htts_pkg::*;

    logic                  valid_reg;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [DELAY_BITS-1:0] period_reg;
    logic                  coop_reg;
    logic [PEND_W-1:0]     pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            delay_reg  <= '0;
            period_reg <= '0;
            coop_reg   <= 1'b0;
            pend_reg   <= '0;
        end
        else
        begin
            priority if (ctrl.load)
            begin
                valid_reg  <= ld_valid;
                delay_reg  <= ld_delay;
                period_reg <= ld_period;
                coop_reg   <= ld_coop;
                pend_reg   <= '0;
            end
            else if (ctrl.shift)
            begin
                valid_reg  <= nb_valid;
                delay_reg  <= nb_delay;
                period_reg <= nb_period;
                coop_reg   <= nb_coop;
                pend_reg   <= nb_pend;
            end
        end
    end

    assign valid  = valid_reg;
    assign delay  = delay_reg;
    assign period = period_reg;
    assign coop   = coop_reg;
    assign pend   = pend_reg;

endmodule

`default_nettype wire

/* design/htts_head.sv */
// ---------------------------------------------------------------------------
// htts_head
// tick update of the slot sitting at the head of the chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htts_head #(
    parameter int DELAY_BITS = htts_pkg::DELAY_BITS_DEF
) (
    input  wire logic                         cur_valid,
    input  wire logic [DELAY_BITS-1:0]        cur_delay,
    input  wire logic [DELAY_BITS-1:0]        cur_period,
    input  wire logic                         cur_coop,
    input  wire logic [htts_pkg::PEND_W-1:0]  cur_pend,
    output logic                              nxt_valid,
    output logic [DELAY_BITS-1:0]             nxt_delay,
    output logic [DELAY_BITS-1:0]             nxt_period,
    output logic                              nxt_coop,
    output logic [htts_pkg::PEND_W-1:0]       nxt_pend,
    output htts_pkg::head_stat_t              stat
);

    import htts_pkg::*;

    always_comb
    begin
        nxt_valid  = cur_valid;
        nxt_delay  = cur_delay;
        nxt_period = cur_period;
        nxt_coop   = cur_coop;
        nxt_pend   = cur_pend;
        stat.due   = 1'b0;
        stat.kind  = KIND_NONE;
        if (cur_valid)
        begin
            if (cur_delay != '0)
            begin
                nxt_delay = DELAY_BITS'(cur_delay - 1'b1);
            end
            else
            begin
                stat.due = 1'b1;
                if (cur_coop)
                begin
                    nxt_pend  = PEND_W'(cur_pend + 1'b1);
                    stat.kind = KIND_COUNT;
                end
                else
                begin
                    nxt_pend  = PEND_W'(cur_pend - 1'b1);
                    nxt_valid = (cur_period != '0);
                    stat.kind = KIND_RUN;
                end
                if (cur_period != '0)
                begin
                    nxt_delay = cur_period;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/hybrid_tick_task_scheduler.sv */
// a load beat's result beat is registered, valid in the cycle after it is accepted
// a tick walks the slot chain one slot per cycle while the output does not stall,
// then passes through a flush state that sends the final result beat of the tick
// the next input beat is taken once the walk and its final result are done
// reset: all slots empty, no result pending; the block is ready at once
// ---------------------------------------------------------------------------
// hybrid tick task scheduler
// slot table held in a rotating chain of cells, updated at the chain head
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hybrid_tick_task_scheduler_assert.svh"

module hybrid_tick_task_scheduler #(
    parameter int TASK_SLOTS = htts_pkg::TASK_SLOTS_DEF,
    parameter int DELAY_BITS = htts_pkg::DELAY_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // slot, task_present, first_delay, repeat_period, cooperative, zero pad
    input  wire logic [htts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // due_slot, pending_runs, zero pad
    output logic [htts_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // kind
    output logic [htts_pkg::KIND_W-1:0]           m_axis_tuser,
    output logic                                  m_axis_tlast
);

    import htts_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [SLOT_W-1:0]        in_slot;
    logic                     in_present;
    logic [FIELD_DELAY_W-1:0] in_delay;
    logic [FIELD_DELAY_W-1:0] in_period;
    logic                     in_coop;
    logic [DELAY_BITS-1:0]    ld_delay;
    logic [DELAY_BITS-1:0]    ld_period;

    logic                  c_valid  [TASK_SLOTS];
    logic [DELAY_BITS-1:0] c_delay  [TASK_SLOTS];
    logic [DELAY_BITS-1:0] c_period [TASK_SLOTS];
    logic                  c_coop   [TASK_SLOTS];
    logic [PEND_W-1:0]     c_pend   [TASK_SLOTS];
    logic                  nb_valid [TASK_SLOTS];
    logic [DELAY_BITS-1:0] nb_delay [TASK_SLOTS];
    logic [DELAY_BITS-1:0] nb_period[TASK_SLOTS];
    logic                  nb_coop  [TASK_SLOTS];
    logic [PEND_W-1:0]     nb_pend  [TASK_SLOTS];
    cell_ctrl_t            cell_ctrl[TASK_SLOTS];

    logic                  h_valid;
    logic [DELAY_BITS-1:0] h_delay;
    logic [DELAY_BITS-1:0] h_period;
    logic                  h_coop;
    logic [PEND_W-1:0]     h_pend;
    head_stat_t            hs;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0] held_slot_reg, held_slot_next;
    logic [KIND_W-1:0] held_kind_reg, held_kind_next;
    logic [PEND_W-1:0] held_pend_reg, held_pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [PEND_W-1:0] out_pend_reg, out_pend_next;
    logic              out_last_reg, out_last_next;

    logic can_push;
    logic in_fire;
    logic load_fire;
    logic tick_fire;
    logic take_new;
    logic need_push;
    logic step;

    assign in_slot    = s_axis_tdata[SLOT_W-1:0];
    assign in_present = s_axis_tdata[IN_PRES_LSB];
    assign in_delay   = s_axis_tdata[IN_DELAY_LSB +: FIELD_DELAY_W];
    assign in_period  = s_axis_tdata[IN_PERIOD_LSB +: FIELD_DELAY_W];
    assign in_coop    = s_axis_tdata[IN_COOP_LSB];
    assign ld_delay   = DELAY_BITS'(in_delay);
    assign ld_period  = DELAY_BITS'(in_period);

    assign can_push      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && can_push;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_fire     = in_fire && (s_axis_tuser == OP_LOAD);
    assign tick_fire     = in_fire && (s_axis_tuser == OP_TICK);

    assign take_new  = (state_reg == ST_WALK) && hs.due && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign need_push = take_new && held_valid_reg;
    assign step      = (state_reg == ST_WALK) && (!need_push || can_push);

    // chain: each cell takes its upper neighbor, the tail takes the updated head
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        if (i == TASK_SLOTS - 1)
        begin : g_tail
            assign nb_valid[i]  = h_valid;
            assign nb_delay[i]  = h_delay;
            assign nb_period[i] = h_period;
            assign nb_coop[i]   = h_coop;
            assign nb_pend[i]   = h_pend;
        end
        else
        begin : g_mid
            assign nb_valid[i]  = c_valid[i+1];
            assign nb_delay[i]  = c_delay[i+1];
            assign nb_period[i] = c_period[i+1];
            assign nb_coop[i]   = c_coop[i+1];
            assign nb_pend[i]   = c_pend[i+1];
        end

        assign cell_ctrl[i].shift = step;
        assign cell_ctrl[i].load  = load_fire && (int'(in_slot) == i);

        htts_cell #(
            .DELAY_BITS(DELAY_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[i]),
            .nb_valid (nb_valid[i]),
            .nb_delay (nb_delay[i]),
            .nb_period(nb_period[i]),
            .nb_coop  (nb_coop[i]),
            .nb_pend  (nb_pend[i]),
            .ld_valid (in_present),
            .ld_delay (ld_delay),
            .ld_period(ld_period),
            .ld_coop  (in_coop),
            .valid    (c_valid[i]),
            .delay    (c_delay[i]),
            .period   (c_period[i]),
            .coop     (c_coop[i]),
            .pend     (c_pend[i])
        );
    end

    htts_head #(
        .DELAY_BITS(DELAY_BITS)
    ) u_head (
        .cur_valid (c_valid[0]),
        .cur_delay (c_delay[0]),
        .cur_period(c_period[0]),
        .cur_coop  (c_coop[0]),
        .cur_pend  (c_pend[0]),
        .nxt_valid (h_valid),
        .nxt_delay (h_delay),
        .nxt_period(h_period),
        .nxt_coop  (h_coop),
        .nxt_pend  (h_pend),
        .stat      (hs)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_kind_next  = held_kind_reg;
        held_pend_next  = held_pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_slot_next   = out_slot_reg;
        out_kind_next   = out_kind_reg;
        out_pend_next   = out_pend_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_fire)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = in_slot;
                    out_kind_next  = KIND_LOAD;
                    out_pend_next  = '0;
                    out_last_next  = 1'b1;
                end
                else if (tick_fire)
                begin
                    state_next      = ST_WALK;
                    idx_next        = '0;
                    cnt_next        = '0;
                    held_valid_next = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (step)
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                    if (take_new)
                    begin
                        // previous due slot goes out, this one is held back
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_slot_next  = held_slot_reg;
                            out_kind_next  = held_kind_reg;
                            out_pend_next  = held_pend_reg;
                            out_last_next  = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_slot_next  = SLOT_W'(idx_reg);
                        held_kind_next  = hs.kind;
                        held_pend_next  = h_pend;
                        cnt_next        = CNT_W'(cnt_reg + 1'b1);
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_slot_next = held_slot_reg;
                        out_kind_next = held_kind_reg;
                        out_pend_next = held_pend_reg;
                    end
                    else
                    begin
                        out_slot_next = '0;
                        out_kind_next = KIND_NONE;
                        out_pend_next = '0;
                    end
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_slot_reg <= held_slot_next;
        held_kind_reg <= held_kind_next;
        held_pend_reg <= held_pend_next;
        out_slot_reg  <= out_slot_next;
        out_kind_reg  <= out_kind_next;
        out_pend_reg  <= out_pend_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_pend_reg, out_slot_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    `HTTS_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_RESULTS), "result count beyond limit")
    `HTTS_ASSERT(a_idle_empty, (state_reg == ST_IDLE) |-> !held_valid_reg, "held beat left in idle")
    `HTTS_ASSERT(a_held_counted, held_valid_reg |-> (cnt_reg != '0), "held beat not counted")
    `HTTS_ASSERT(a_walk_end, (step && (idx_reg == IDX_LAST)) |=> (state_reg == ST_FLUSH), "walk end missed")
    `HTTS_ASSERT(a_none_last, (m_axis_tvalid && (m_axis_tuser == KIND_NONE)) |-> m_axis_tlast, "idle tick beat not last")
    `HTTS_ASSERT_RST(a_rst_quiet, !rst_n |=> !m_axis_tvalid, "output beat during reset")

endmodule

`default_nettype wire
